@@ hw/rtl/tssm_pkg.sv @@
package tssm_pkg;

    localparam int DEPTH    = 512;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int NSTACKS  = 3;
    localparam int SIZE_W   = 10;
    localparam int CNT_W    = 8;
    localparam int MAX_SIZE = 512;

    localparam logic       CMD_PUSH = 1'b0;
    localparam logic       CMD_POP  = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADSEL = 2'd3;

    typedef struct packed {
        logic       cmd;
        logic [1:0] stack_select;
        logic [7:0] push_value;
    } stack_req_t;

    typedef struct packed {
        logic [7:0] pop_value;
        logic [1:0] status;
    } stack_rsp_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic cfg_wr;
    } dp_cmd_t;

endpackage

@@ hw/rtl/tssm_ctrl.sv @@
module tssm_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output logic             done,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    output tssm_pkg::dp_cmd_t dp_cmd
);
    import tssm_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   done_reg;
    logic   done_next;

    always_comb
    begin
        state_next = state_reg;
        done_next  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign busy      = (state_reg == S_EXEC);
    assign done      = done_reg;
    assign cfg_ready = (state_reg == S_IDLE);

    assign dp_cmd.load   = start && (state_reg == S_IDLE);
    assign dp_cmd.exec   = (state_reg == S_EXEC);
    assign dp_cmd.cfg_wr = cfg_valid && (state_reg == S_IDLE);

    // an accepted transaction is executed in the very next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction not executed");

    // execution ends in the following cycle, raising done
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (!busy && done))
        else $error("execution did not finish in one cycle");

    // the strobe only follows an execution cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without execution");

endmodule

@@ hw/rtl/tssm_datapath.sv @@
module tssm_datapath
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  tssm_pkg::dp_cmd_t             dp_cmd,
    input  tssm_pkg::stack_req_t          req,
    input  logic [tssm_pkg::SIZE_W-1:0]   cfg_wdata,
    output tssm_pkg::stack_rsp_t          rsp
);
    import tssm_pkg::*;

    // floor(s/3) as (s * 683) >> 11, exact for s up to 512
    localparam int RECIP3       = 683;
    localparam int RECIP3_SHIFT = 11;
    localparam int PROD_W       = SIZE_W + 10;

    // configuration, held as the split it implies
    logic [CNT_W-1:0]  part_reg;
    logic [CNT_W-1:0]  part_next;
    logic [CNT_W-1:0]  cap2_reg;
    logic [CNT_W-1:0]  cap2_next;

    logic [SIZE_W-1:0] size_clamped;
    logic [PROD_W-1:0] prod;
    logic [SIZE_W-1:0] three_q;
    logic [1:0]        rem;

    // latched transaction
    stack_req_t        req_reg;

    logic [CNT_W-1:0]  cnt_reg [NSTACKS];
    logic [CNT_W-1:0]  cnt_sel;
    logic [CNT_W-1:0]  cap;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status_next;
    logic              mem_we;
    logic              cnt_inc;
    logic              cnt_dec;

    logic [7:0]        mem [DEPTH];
    logic [7:0]        rd_data_reg;
    logic [1:0]        status_reg;
    logic              pop_ok_reg;

    always_comb
    begin
        if (cfg_wdata > SIZE_W'(MAX_SIZE))
        begin
            size_clamped = SIZE_W'(MAX_SIZE);
        end
        else
        begin
            size_clamped = cfg_wdata;
        end
        prod      = PROD_W'(size_clamped) * PROD_W'(RECIP3);
        part_next = CNT_W'(prod >> RECIP3_SHIFT);
        three_q   = SIZE_W'(part_next) + SIZE_W'({part_next, 1'b0});
        rem       = 2'(size_clamped - three_q);
        cap2_next = part_next + CNT_W'(rem);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            part_reg <= CNT_W'(MAX_SIZE / NSTACKS);
            cap2_reg <= CNT_W'(MAX_SIZE / NSTACKS + MAX_SIZE % NSTACKS);
        end
        else if (dp_cmd.cfg_wr)
        begin
            part_reg <= part_next;
            cap2_reg <= cap2_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            req_reg <= req;
        end
    end

    always_comb
    begin
        cnt_sel     = '0;
        cap         = part_reg;
        base        = '0;
        addr        = '0;
        status_next = ST_OK;
        mem_we      = 1'b0;
        cnt_inc     = 1'b0;
        cnt_dec     = 1'b0;
        case (req_reg.stack_select)
            2'd0:
            begin
                cnt_sel = cnt_reg[0];
                base    = '0;
            end
            2'd1:
            begin
                cnt_sel = cnt_reg[1];
                base    = ADDR_W'(part_reg);
            end
            2'd2:
            begin
                cnt_sel = cnt_reg[2];
                cap     = cap2_reg;
                base    = ADDR_W'({part_reg, 1'b0});
            end
            default:
            begin
                status_next = ST_BADSEL;
            end
        endcase
        if (status_next != ST_BADSEL)
        begin
            if (req_reg.cmd == CMD_PUSH)
            begin
                addr = base + ADDR_W'(cnt_sel);
                if (cnt_sel >= cap)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    mem_we  = dp_cmd.exec;
                    cnt_inc = dp_cmd.exec;
                end
            end
            else
            begin
                // addresses wrap at the memory depth
                addr = base + ADDR_W'(cnt_sel) - ADDR_W'(1);
                if (cnt_sel == '0)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    cnt_dec = dp_cmd.exec;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSTACKS; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NSTACKS; i++)
            begin
                if (req_reg.stack_select == 2'(i))
                begin
                    if (cnt_inc)
                    begin
                        cnt_reg[i] <= cnt_reg[i] + CNT_W'(1);
                    end
                    else if (cnt_dec)
                    begin
                        cnt_reg[i] <= cnt_reg[i] - CNT_W'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[addr] <= req_reg.push_value;
        end
        if (dp_cmd.exec)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.exec)
        begin
            status_reg <= status_next;
            pop_ok_reg <= (status_next == ST_OK) && (req_reg.cmd == CMD_POP);
        end
    end

    assign rsp.pop_value = pop_ok_reg ? rd_data_reg : 8'd0;
    assign rsp.status    = status_reg;

endmodule

@@ hw/rtl/three_stacks_shared_memory_unit.sv @@
// channel    | signals                       | transaction when
// -----------+-------------------------------+------------------------------
// command    | start, busy, req              | start high and busy low
// result     | done, rsp                     | done high (one cycle only)
// config     | cfg_valid, cfg_ready, cfg_wdata | cfg_valid and cfg_ready high
//
// a transaction has an execution cycle, in which the single memory port is
// read or written and the fill count moves, then the result cycle
// in the result cycle busy is already low, so a new start is accepted there
// reset clears the fill counts and sets the size to 512; memory is not cleared
// the receiver cannot stall: each result shows for exactly one cycle
module three_stacks_shared_memory_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  tssm_pkg::stack_req_t        req,
    output logic                        done,
    output tssm_pkg::stack_rsp_t        rsp,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [tssm_pkg::SIZE_W-1:0] cfg_wdata
);
    import tssm_pkg::*;

    dp_cmd_t dp_cmd;

    tssm_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .done      (done),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .dp_cmd    (dp_cmd)
    );

    tssm_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .dp_cmd    (dp_cmd),
        .req       (req),
        .cfg_wdata (cfg_wdata),
        .rsp       (rsp)
    );

endmodule

@@ test/three_stacks_shared_memory_unit_tb.sv @@
`timescale 1ns / 100ps

module three_stacks_shared_memory_unit_tb;
    import tssm_pkg::*;

    localparam int          QUIET_LIMIT = 2000;
    localparam int          PHASE_ITEMS = 110;
    localparam int          REQ_W       = $bits(stack_req_t);
    localparam logic [1:0]  BAD_SELECT  = 2'(NSTACKS);

    // tracks fill counts and memory contents, predicts each response
    class shared_stack_tracker;
        bit [7:0]        mem_image [DEPTH];
        bit              mem_written [DEPTH];
        bit [CNT_W-1:0]  fill [NSTACKS];
        bit [SIZE_W-1:0] size_reg = SIZE_W'(MAX_SIZE);
        stack_rsp_t      awaited_rsp_q [$];
        int              mismatches;

        function int unsigned usable_size();
            int unsigned s;
            s = size_reg;
            if (s > MAX_SIZE)
                s = MAX_SIZE;
            if (s > DEPTH)
                s = DEPTH;
            return s;
        endfunction

        function int unsigned part_base(int unsigned sel);
            return (usable_size() / NSTACKS) * sel;
        endfunction

        // last partition also takes the remainder
        function int unsigned part_cap(int unsigned sel);
            int unsigned cap;
            cap = usable_size() / NSTACKS;
            if (sel == NSTACKS - 1)
                cap += usable_size() % NSTACKS;
            return cap;
        endfunction

        function int unsigned top_addr(int unsigned sel);
            return (part_base(sel) + fill[sel] - 1) % DEPTH;
        endfunction

        // a pop must never land on an entry that was never written
        function bit pop_is_safe(logic [1:0] sel);
            if (sel >= NSTACKS || fill[sel] == 0)
                return 1'b1;
            return mem_written[top_addr(sel)];
        endfunction

        function int pending();
            return awaited_rsp_q.size();
        endfunction

        function void set_size(logic [SIZE_W-1:0] value);
            size_reg = value;
        endfunction

        function void note_request(stack_req_t r);
            stack_rsp_t  want;
            int unsigned sel;
            int unsigned addr;
            want        = '0;
            want.status = ST_OK;
            sel         = r.stack_select;
            if (sel >= NSTACKS)
                want.status = ST_BADSEL;
            else if (r.cmd == CMD_PUSH)
            begin
                if (fill[sel] >= part_cap(sel))
                    want.status = ST_FULL;
                else
                begin
                    addr              = (part_base(sel) + fill[sel]) % DEPTH;
                    mem_image[addr]   = r.push_value;
                    mem_written[addr] = 1'b1;
                    fill[sel]         = fill[sel] + 1'b1;
                end
            end
            else
            begin
                if (fill[sel] == 0)
                    want.status = ST_EMPTY;
                else
                begin
                    want.pop_value = mem_image[top_addr(sel)];
                    fill[sel]      = fill[sel] - 1'b1;
                end
            end
            awaited_rsp_q.push_back(want);
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_response(stack_rsp_t got);
            stack_rsp_t want;
            if (awaited_rsp_q.size() == 0)
            begin
                report($sformatf("result with no transaction outstanding: %02h status %0d",
                                 got.pop_value, got.status));
                return;
            end
            want = awaited_rsp_q.pop_front();
            if (got.pop_value !== want.pop_value)
                report($sformatf("pop_value %02h, wanted %02h", got.pop_value, want.pop_value));
            if (got.status !== want.status)
                report($sformatf("status %0d, wanted %0d", got.status, want.status));
        endtask
    endclass

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    stack_req_t        req;
    logic              done;
    stack_rsp_t        rsp;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_wdata;

    shared_stack_tracker tracker;
    int unsigned         quiet_cycles = 0;

    three_stacks_shared_memory_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            tracker.check_response(rsp);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    task automatic send_item(stack_req_t r);
        start <= 1'b1;
        req   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        tracker.note_request(r);
    endtask

    task automatic send_op(logic cmd, logic [1:0] sel, logic [7:0] value);
        stack_req_t r;
        r.cmd          = cmd;
        r.stack_select = sel;
        r.push_value   = value;
        send_item(r);
    endtask

    // request lines carry noise while start is low
    task automatic idle_for(int unsigned cycles);
        start <= 1'b0;
        req   <= stack_req_t'(REQ_W'($urandom));
        repeat (cycles)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_wdata <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        tracker.set_size(value);
        cfg_valid <= 1'b0;
    endtask

    function automatic int unsigned pick_gap(bit no_idle);
        int unsigned roll;
        if (no_idle)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic stack_req_t random_request(int unsigned push_pct, logic [1:0] fav);
        stack_req_t r;
        r.push_value = 8'($urandom);
        r.cmd        = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
        if ($urandom_range(0, 15) == 0)
            r.stack_select = BAD_SELECT;
        else if ($urandom_range(0, 1) == 1)
            r.stack_select = fav;
        else
            r.stack_select = 2'($urandom_range(0, NSTACKS - 1));
        if (r.cmd == CMD_POP && !tracker.pop_is_safe(r.stack_select))
            r.cmd = CMD_PUSH;
        return r;
    endfunction

    initial
    begin
        logic [SIZE_W-1:0] phase_sizes [12];
        logic [1:0]        fav;
        bit                no_idle;
        int unsigned       gap;

        tracker   = new();
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_wdata = '0;
        phase_sizes = '{10'd0, 10'd1023, 10'd2, 10'd30, 10'd1, 10'd513,
                        10'd3, 10'd12, 10'd512, 10'd7, 10'd100, 10'd4};
        phase_sizes[11] = SIZE_W'($urandom_range(1, 1023));

        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // capacities 1, 1 and 3, so full and empty come quickly
        write_size(10'd5);
        send_op(CMD_POP,  2'd0, 8'h3C);
        send_op(CMD_POP,  2'd1, 8'hC3);
        send_op(CMD_POP,  2'd2, 8'h00);
        send_op(CMD_PUSH, 2'd0, 8'hFF);
        send_op(CMD_PUSH, 2'd0, 8'h5A);
        send_op(CMD_PUSH, 2'd1, 8'h00);
        send_op(CMD_PUSH, 2'd1, 8'hA5);
        send_op(CMD_PUSH, 2'd2, 8'h01);
        send_op(CMD_PUSH, 2'd2, 8'h80);
        send_op(CMD_PUSH, 2'd2, 8'h7E);
        send_op(CMD_PUSH, 2'd2, 8'h55);
        send_op(CMD_PUSH, BAD_SELECT, 8'hAA);
        send_op(CMD_POP,  BAD_SELECT, 8'hFF);
        send_op(CMD_POP,  2'd2, 8'hFF);
        send_op(CMD_POP,  2'd2, 8'h00);
        send_op(CMD_POP,  2'd2, 8'h11);
        send_op(CMD_POP,  2'd2, 8'h22);
        send_op(CMD_POP,  2'd1, 8'h33);
        send_op(CMD_POP,  2'd0, 8'h44);
        send_op(CMD_POP,  2'd0, 8'h66);
        // left in place so the next size change finds data
        send_op(CMD_PUSH, 2'd2, 8'hC3);
        wait_drained();

        // each phase fills for half its items, then drains
        foreach (phase_sizes[p])
        begin
            write_size(phase_sizes[p]);
            fav     = 2'($urandom_range(0, NSTACKS - 1));
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                    wait_drained();
                send_item(random_request((i < PHASE_ITEMS / 2) ? 85 : 15, fav));
                gap = pick_gap(no_idle);
                if (gap != 0)
                    idle_for(gap);
            end
            wait_drained();
        end

        repeat (4)
            @(posedge clk);
        if (tracker.pending() != 0)
            tracker.report($sformatf("%0d results never arrived", tracker.pending()));
        if (tracker.mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
